// ----- rtl/core/ect_pkg.sv -----
// ============================================================================
// ect_pkg: shared types and constants of the expression character tokenizer
// Token kinds, keyword progress codes, the token and bundle records that
// travel from the front end through the queue to the back end, and the
// character classification helpers.
// ============================================================================
`default_nettype none

package ect_pkg;

    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 4;
    localparam int START_W     = 12;
    localparam int LEN_W       = 13;
    localparam int SLOTS       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int KW_W        = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_ID      = 4'd0,
        KIND_INT     = 4'd1,
        KIND_FLOAT   = 4'd2,
        KIND_TRUE    = 4'd3,
        KIND_FALSE   = 4'd4,
        KIND_PLUS    = 4'd5,
        KIND_MINUS   = 4'd6,
        KIND_MUL     = 4'd7,
        KIND_DIV     = 4'd8,
        KIND_ASSIGN  = 4'd9,
        KIND_LPAREN  = 4'd10,
        KIND_RPAREN  = 4'd11,
        KIND_END     = 4'd12,
        KIND_INVALID = 4'd13
    } kind_t;

    // Keyword progress: how much of "true" or "false" has been matched so far.
    localparam logic [KW_W-1:0] KW_NONE  = 4'd0;
    localparam logic [KW_W-1:0] KW_T1    = 4'd1;
    localparam logic [KW_W-1:0] KW_T2    = 4'd2;
    localparam logic [KW_W-1:0] KW_T3    = 4'd3;
    localparam logic [KW_W-1:0] KW_TRUE  = 4'd4;
    localparam logic [KW_W-1:0] KW_F1    = 4'd5;
    localparam logic [KW_W-1:0] KW_F2    = 4'd6;
    localparam logic [KW_W-1:0] KW_F3    = 4'd7;
    localparam logic [KW_W-1:0] KW_F4    = 4'd8;
    localparam logic [KW_W-1:0] KW_FALSE = 4'd9;

    typedef struct packed {
        kind_t                kind;
        logic [START_W-1:0]   start;
        logic [LEN_W-1:0]     length;
        logic [CHAR_W-1:0]    bad;
    } token_t;

    // Up to three tokens caused by one character, emitted lowest slot first.
    typedef struct packed {
        logic [SLOTS-1:0]     valid;
        token_t [SLOTS-1:0]   slot;
    } bundle_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c inside {[8'd9:8'd13], " "};
    endfunction

    function automatic kind_t operator_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        case (c)
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_MUL;
            "/":     k = KIND_DIV;
            "=":     k = KIND_ASSIGN;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            default: k = KIND_INVALID;
        endcase
        return k;
    endfunction

    function automatic logic [KW_W-1:0] keyword_next(input logic [KW_W-1:0] p,
                                                      input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] want;
        logic              open;
        open = 1'b1;
        want = '0;
        case (p)
            KW_T1:   want = "r";
            KW_T2:   want = "u";
            KW_T3:   want = "e";
            KW_F1:   want = "a";
            KW_F2:   want = "l";
            KW_F3:   want = "s";
            KW_F4:   want = "e";
            default: open = 1'b0;
        endcase
        return (open && c == want) ? p + KW_W'(1) : KW_NONE;
    endfunction

    function automatic kind_t run_kind(input logic is_num, input logic is_float,
                                       input logic [KW_W-1:0] kw);
        kind_t k;
        if (is_num)
            k = is_float ? KIND_FLOAT : KIND_INT;
        else if (kw == KW_TRUE)
            k = KIND_TRUE;
        else if (kw == KW_FALSE)
            k = KIND_FALSE;
        else
            k = KIND_ID;
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ect_front.sv -----
// ============================================================================
// ect_front: character classifier and run tracker
// Holds the open run, keyword progress and position, and turns each
// accepted character into a bundle of up to three tokens.
// ============================================================================
`default_nettype none

module ect_front #(
    parameter int MAX_LINE = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [ect_pkg::CHAR_W-1:0]  character,
    input  wire logic                        end_of_input,
    output logic                             push,
    output ect_pkg::bundle_t                 bundle
);

    localparam int PW = $clog2(MAX_LINE);
    localparam int LW = $clog2(MAX_LINE + 1);

    typedef enum logic [2:0] {
        MODE_NONE = 3'b001,
        MODE_ID   = 3'b010,
        MODE_NUM  = 3'b100
    } mode_t;

    mode_t                        mode_reg, mode_next;
    logic                         float_reg, float_next;
    logic [PW-1:0]                start_reg, start_next;
    logic [LW-1:0]                len_reg, len_next;
    logic [ect_pkg::KW_W-1:0]     kw_reg, kw_next;
    logic [PW-1:0]                pos_reg, pos_next;

    logic letter, digit, dot, space, ext_id, ext_num, extend;
    ect_pkg::kind_t op_kind;

    always_comb
    begin
        letter  = ect_pkg::is_letter(character);
        digit   = ect_pkg::is_digit(character);
        space   = ect_pkg::is_space(character);
        dot     = (character == ".");
        ext_id  = (mode_reg == MODE_ID) && (letter || digit);
        ext_num = (mode_reg == MODE_NUM) && (digit || dot);
        extend  = ext_id || ext_num;
        op_kind = ect_pkg::operator_kind(character);

        mode_next  = mode_reg;
        float_next = float_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kw_next    = kw_reg;
        pos_next   = (pos_reg != PW'(MAX_LINE - 1)) ? pos_reg + PW'(1) : pos_reg;
        bundle     = '0;

        // The run closed by this character goes out first.
        bundle.valid[0]        = !extend && (mode_reg != MODE_NONE);
        bundle.slot[0].kind    = ect_pkg::run_kind(mode_reg == MODE_NUM, float_reg, kw_reg);
        bundle.slot[0].start   = ect_pkg::START_W'(start_reg);
        bundle.slot[0].length  = ect_pkg::LEN_W'(len_reg);

        if (extend)
        begin
            if (ext_id)
                kw_next = ect_pkg::keyword_next(kw_reg, character);
            if (ext_num && dot)
                float_next = 1'b1;
            if (len_reg != LW'(MAX_LINE))
                len_next = len_reg + LW'(1);
        end
        else
        begin
            mode_next = MODE_NONE;
            if (letter || digit)
            begin
                mode_next  = letter ? MODE_ID : MODE_NUM;
                float_next = 1'b0;
                start_next = pos_reg;
                len_next   = LW'(1);
                kw_next    = (character == "t") ? ect_pkg::KW_T1 :
                             (character == "f") ? ect_pkg::KW_F1 : ect_pkg::KW_NONE;
            end
            else if (!space)
            begin
                bundle.valid[1]       = 1'b1;
                bundle.slot[1].kind   = op_kind;
                bundle.slot[1].start  = ect_pkg::START_W'(pos_reg);
                bundle.slot[1].length = ect_pkg::LEN_W'(1);
                bundle.slot[1].bad    = (op_kind == ect_pkg::KIND_INVALID) ? character : '0;
            end
        end

        if (end_of_input)
        begin
            // A run still open at end of line cannot share a step with an
            // operator token, so it reuses the middle slot.
            if (mode_next != MODE_NONE)
            begin
                bundle.valid[1]       = 1'b1;
                bundle.slot[1].kind   = ect_pkg::run_kind(mode_next == MODE_NUM,
                                                          float_next, kw_next);
                bundle.slot[1].start  = ect_pkg::START_W'(start_next);
                bundle.slot[1].length = ect_pkg::LEN_W'(len_next);
                bundle.slot[1].bad    = '0;
            end
            bundle.valid[2]       = 1'b1;
            bundle.slot[2].kind   = ect_pkg::KIND_END;
            bundle.slot[2].start  = ect_pkg::START_W'(pos_next);
            mode_next  = MODE_NONE;
            float_next = 1'b0;
            start_next = '0;
            len_next   = '0;
            kw_next    = ect_pkg::KW_NONE;
            pos_next   = '0;
        end

        push = accept && (bundle.valid != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NONE;
            float_reg <= 1'b0;
            start_reg <= '0;
            len_reg   <= '0;
            kw_reg    <= ect_pkg::KW_NONE;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            float_reg <= float_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
            pos_reg   <= pos_next;
        end
    end

    a_eol_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_input |=> pos_reg == '0 && mode_reg == MODE_NONE)
        else $error("line did not restart after end of input");

    a_end_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (bundle.valid[2] == end_of_input))
        else $error("end token slot does not follow end of input");

endmodule

`default_nettype wire

// ----- rtl/core/ect_queue.sv -----
// ============================================================================
// ect_queue: bundle queue between front and back end
// A small register queue that lets the front end run ahead of a stalled
// output while the back end drains earlier bundles.
// ============================================================================
`default_nettype none

module ect_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ect_pkg::bundle_t  push_data,
    output logic                   full,
    input  wire logic              pop,
    output ect_pkg::bundle_t       pop_data,
    output logic                   empty
);

    localparam int AW = $clog2(ect_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(ect_pkg::QUEUE_DEPTH + 1);

    ect_pkg::bundle_t  entry_reg [ect_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    assign full     = (count_reg == CW'(ect_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/ect_back.sv -----
// ============================================================================
// ect_back: token serializer
// Holds one bundle and presents its tokens one per transaction, marking the
// final one, and fetches the next bundle as the current one drains.
// ============================================================================
`default_nettype none

module ect_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire ect_pkg::bundle_t  q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ect_pkg::token_t        tok,
    output logic                   tok_last
);

    ect_pkg::bundle_t              bundle_reg;
    logic [ect_pkg::SLOTS-1:0]     mask_reg, mask_next;
    logic [ect_pkg::SLOTS-1:0]     pick, rest;
    logic                          taken;

    always_comb
    begin
        pick      = mask_reg & (~mask_reg + ect_pkg::SLOTS'(1));
        rest      = mask_reg & ~pick;
        out_valid = (mask_reg != '0);
        tok_last  = (rest == '0);
        taken     = out_valid && out_ready;
        tok       = bundle_reg.slot[2];
        if (pick[0])
            tok = bundle_reg.slot[0];
        else if (pick[1])
            tok = bundle_reg.slot[1];

        q_pop     = !q_empty && (!out_valid || (taken && tok_last));
        mask_next = mask_reg;
        if (q_pop)
            mask_next = q_data.valid;
        else if (taken)
            mask_next = rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            bundle_reg <= q_data;
    end

    a_end_slot_kind: assert property (@(posedge clk) disable iff (!rst_n)
        mask_reg[2] |-> bundle_reg.slot[2].kind == ect_pkg::KIND_END)
        else $error("last slot holds something other than an end token");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tok.kind == ect_pkg::KIND_END |-> tok_last)
        else $error("end token not marked as last");

endmodule

`default_nettype wire

// ----- rtl/core/expression_char_tokenizer.sv -----
// ============================================================================
// expression_char_tokenizer: byte stream to token stream
// Cuts expression text into identifier, keyword, number, operator, invalid
// and end tokens, each reported as kind, start offset and length.
// ============================================================================
// Usage: the input channel (in_valid/in_ready) takes one byte of text per
// transaction together with end_of_input, which marks the last byte of a
// line. The output channel (out_valid/out_ready) gives one token per
// transaction; last is set on the final token caused by an input byte.
// A byte causes zero to three tokens: the run it closes, its own operator
// or invalid token, and at end of line the open run and an END token.
// Each token's bundle is registered in the queue, then in the back end,
// before the token appears. Throughput: one byte per cycle in while the
// queue is not full, one token per cycle out while out_ready is high. The
// front end classifies bytes and writes each nonempty token bundle into a
// four-entry queue; the back end drains one token a cycle when out_ready is
// high. The input stalls only when that queue is full, so a slow receiver
// holds back the input once four bundles wait behind the one being drained.
// Reset clears the open run and the position counter; the first byte after
// reset, like the first after an end of line, sits at offset zero.
// Position and length saturate at MAX_LINE-1 and MAX_LINE.
// ============================================================================
`default_nettype none

module expression_char_tokenizer #(
    parameter int MAX_LINE = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ect_pkg::CHAR_W-1:0]    character,
    input  wire logic                          end_of_input,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ect_pkg::KIND_W-1:0]         kind,
    output logic [ect_pkg::START_W-1:0]        start_position,
    output logic [ect_pkg::LEN_W-1:0]          token_length,
    output logic [ect_pkg::CHAR_W-1:0]         bad_character,
    output logic                               last
);

    logic              accept;
    logic              push, full, pop, empty;
    ect_pkg::bundle_t  front_bundle, head_bundle;
    ect_pkg::token_t   tok;

    // A byte is taken whenever the queue has room for its bundle.
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    ect_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .character    (character),
        .end_of_input (end_of_input),
        .push         (push),
        .bundle       (front_bundle)
    );

    ect_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_bundle),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_bundle),
        .empty     (empty)
    );

    ect_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .q_data    (head_bundle),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tok       (tok),
        .tok_last  (last)
    );

    // Token fields map straight onto the output ports.
    assign kind           = tok.kind;
    assign start_position = tok.start;
    assign token_length   = tok.length;
    assign bad_character  = tok.bad;

endmodule

`default_nettype wire
